/* rtl/core/sdf_pkg.sv */
package sdf_pkg;

   localparam int DIGIT_COUNT = 6;
   localparam int LINE_LEN = DIGIT_COUNT + 6;
   localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int POS_W = $clog2(LINE_LEN);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   localparam logic [POS_W-1:0] POS_TAG = POS_W'(0);
   localparam logic [POS_W-1:0] POS_COLON = POS_W'(1);
   localparam logic [POS_W-1:0] POS_GAP = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SIGN = POS_W'(3);
   localparam logic [POS_W-1:0] POS_FIRST_DIGIT = POS_W'(4);
   localparam logic [POS_W-1:0] POS_LAST_DIGIT = POS_W'(DIGIT_COUNT + 3);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LEN - 1);

   typedef struct packed {
      logic signed [31:0] reading;
      logic [7:0] tag_char;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic end_of_line;
   } rsp_type;

   typedef struct packed {
      logic [7:0] tag_char;
      logic neg;
      logic [DIGIT_COUNT-1:0][3:0] digits;
   } line_type;

endpackage

/* rtl/core/sdf_front.sv */
module sdf_front (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input sdf_pkg::req_type req_data,
   output logic q_push,
   input logic q_full,
   output sdf_pkg::line_type q_data
);
   import sdf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_PUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic [7:0] tag_ff, tag_in;
   logic neg_ff, neg_in;
   logic [DIGIT_COUNT-1:0][3:0] digits_ff, digits_in;
   logic [DIGIT_IDX_W-1:0] step_ff, step_in;

   logic [63:0] product;
   logic [31:0] quotient;
   logic [3:0] rem_digit;

   assign product = {32'b0, mag_ff} * {32'b0, DIV10_RECIP};
   assign quotient = 32'(product >> DIV10_SHIFT);
   assign rem_digit = mag_ff[3:0] - {quotient[0], 3'b000} - {quotient[2:0], 1'b0};

   assign full = (state_ff != ST_IDLE);
   assign q_push = (state_ff == ST_PUSH) && !q_full;
   assign q_data = '{tag_char: tag_ff, neg: neg_ff, digits: digits_ff};

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      tag_in = tag_ff;
      neg_in = neg_ff;
      digits_in = digits_ff;
      step_in = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push) begin
               neg_in = req_data.reading[31];
               mag_in = req_data.reading[31] ? 32'(32'd0 - req_data.reading)
                                             : 32'(req_data.reading);
               tag_in = req_data.tag_char;
               step_in = DIGIT_IDX_W'(DIGIT_COUNT - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in = quotient;
            for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
               digits_in[i] = digits_ff[i + 1];
            end
            digits_in[DIGIT_COUNT - 1] = rem_digit;
            if (step_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               step_in = step_ff - DIGIT_IDX_W'(1);
            end
         end
         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      tag_ff <= tag_in;
      neg_ff <= neg_in;
      digits_ff <= digits_in;
      step_ff <= step_in;
   end

endmodule

/* rtl/core/sdf_queue.sv */
module sdf_queue (
   input logic clock,
   input logic reset,
   input logic wr_en,
   input sdf_pkg::line_type wr_data,
   output logic full,
   input logic rd_en,
   output sdf_pkg::line_type rd_data,
   output logic empty
);
   import sdf_pkg::*;

   line_type entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/sdf_back.sv */
module sdf_back (
   input logic clock,
   input logic reset,
   input logic q_empty,
   input sdf_pkg::line_type q_head,
   output logic q_pop,
   output logic empty,
   input logic pop,
   output sdf_pkg::rsp_type rsp_data
);
   import sdf_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic load;
   logic last;
   logic [POS_W-1:0] digit_sel;
   logic [3:0] digit;
   logic [7:0] next_char;

   assign load = !q_empty && (!rsp_valid_ff || pop);
   assign last = (pos_ff == POS_LAST);
   assign q_pop = load && last;
   assign digit_sel = POS_LAST_DIGIT - pos_ff;
   assign digit = q_head.digits[digit_sel[DIGIT_IDX_W-1:0]];

   always_comb begin
      case (pos_ff) inside
         POS_TAG: next_char = q_head.tag_char;
         POS_COLON: next_char = CHAR_COLON;
         POS_GAP: next_char = CHAR_SPACE;
         POS_SIGN: next_char = q_head.neg ? CHAR_MINUS : CHAR_SPACE;
         [POS_FIRST_DIGIT:POS_LAST_DIGIT]: next_char = CHAR_ZERO | {4'b0000, digit};
         default: next_char = CHAR_SPACE;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (load) begin
         rsp_in = '{text_char: next_char, end_of_line: last};
         rsp_valid_in = 1'b1;
         pos_in = last ? '0 : pos_ff + POS_W'(1);
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

/* rtl/core/signed_decimal_text_formatter_top.sv */
// Channel    Ports                          Moves
// request    push, full, req_data           one reading and its label
// response   empty, pop, rsp_data           one character of the line
//
// A request is taken while the front is idle, then converted one decimal digit
// per cycle by a multiply-by-reciprocal unit and pushed into the queue.
// The back emits LINE_LEN characters, one per cycle while pop is held high, and
// that output rate sets the sustained throughput of requests. A two-line queue
// between front and back lets the next request be converted while the current
// line is still being read out; a stalled pop holds the output register and, once
// the queue fills, the front. Reset is synchronous and clears all control state.
module signed_decimal_text_formatter_top (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input sdf_pkg::req_type req_data,
   output logic empty,
   input logic pop,
   output sdf_pkg::rsp_type rsp_data
);
   import sdf_pkg::*;

   logic q_push;
   logic q_full;
   logic q_pop;
   logic q_empty;
   line_type q_wr_data;
   line_type q_head;

   sdf_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .q_push(q_push),
      .q_full(q_full),
      .q_data(q_wr_data)
   );

   sdf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(q_push),
      .wr_data(q_wr_data),
      .full(q_full),
      .rd_en(q_pop),
      .rd_data(q_head),
      .empty(q_empty)
   );

   sdf_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

`ifndef SYNTH
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("Front pushed a line into a full queue.");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("Back released a line from an empty queue.");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("Front did not go busy after taking a request.");

   a_eol_pops: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (!empty && rsp_data.end_of_line))
      else $error("Line end was not flagged on the last character.");
`endif

endmodule

/* tb/signed_decimal_text_formatter_top_test.sv */
`timescale 1ns / 100ps

module signed_decimal_text_formatter_top_test;

   import sdf_pkg::*;

   localparam int RANDOM_READINGS = 360;
   localparam int SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_data;

   req_type pending_readings[$];
   rsp_type expected_chars[$];
   int failures = 0;

   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int stall_phase = 0;

   signed_decimal_text_formatter_top dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic format_expected_line(input req_type request);
      logic [31:0] magnitude;
      logic negative;
      logic [7:0] line_chars[LINE_LEN];
      rsp_type text;
      negative = request.reading[31];
      magnitude = negative ? 32'd0 - request.reading : request.reading;
      line_chars[0] = request.tag_char;
      line_chars[1] = CHAR_COLON;
      line_chars[2] = CHAR_SPACE;
      line_chars[3] = negative ? CHAR_MINUS : CHAR_SPACE;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         line_chars[3 + DIGIT_COUNT - i] = CHAR_ZERO + 8'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
      end
      line_chars[LINE_LEN - 2] = CHAR_SPACE;
      line_chars[LINE_LEN - 1] = CHAR_SPACE;
      for (int i = 0; i < LINE_LEN; i++) begin
         text.text_char = line_chars[i];
         text.end_of_line = (i == LINE_LEN - 1);
         expected_chars.push_back(text);
      end
   endtask

   task automatic check_char(input rsp_type actual);
      rsp_type wanted;
      if (expected_chars.size() == 0) begin
         $error("unexpected character: text_char %h end_of_line %b",
            actual.text_char, actual.end_of_line);
         failures++;
      end else begin
         wanted = expected_chars.pop_front();
         if (actual.text_char !== wanted.text_char) begin
            $error("text_char: expected %h, actual %h", wanted.text_char, actual.text_char);
            failures++;
         end
         if (actual.end_of_line !== wanted.end_of_line) begin
            $error("end_of_line: expected %b, actual %b",
               wanted.end_of_line, actual.end_of_line);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            format_expected_line(req_data);
            void'(pending_readings.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            end
         end
         if (push && full) begin
            push <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_readings.size() > 0) begin
            push <= 1'b1;
            req_data <= pending_readings[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            check_char(rsp_data);
         end
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 120);
         end
         stall_span--;
         stall_phase = (stall_phase + 1) % 5;
         case (stall_mode)
            0: begin
               pop <= 1'b1;
            end
            1: begin
               pop <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               pop <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               pop <= (stall_phase == 0);
            end
         endcase
      end
   end

   initial begin
      static logic signed [31:0] directed[] = '{
         32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
         32'sd999999, 32'sd1000000, -32'sd999999, -32'sd1000000, 32'sd123456,
         -32'sd654321, 32'sd9, 32'sd10, -32'sd10, 32'sd100000, 32'sd1234567,
         -32'sd2147483647, 32'sh5555_5555, 32'shAAAA_AAAA
      };
      static logic [7:0] directed_tags[] = '{8'h00, 8'hFF, 8'h41, 8'h55, 8'hAA, 8'h7A};
      req_type request;
      logic [31:0] power;
      int exponent;
      for (int i = 0; i < directed.size(); i++) begin
         request.reading = directed[i];
         request.tag_char = directed_tags[i % directed_tags.size()];
         pending_readings.push_back(request);
      end
      for (int i = 0; i < RANDOM_READINGS; i++) begin
         request.tag_char = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 3))
            0: begin
               request.reading = $urandom;
            end
            1: begin
               request.reading = $urandom_range(0, 999999);
            end
            2: begin
               request.reading = $urandom_range(0, 99);
            end
            default: begin
               exponent = $urandom_range(0, 9);
               power = 32'd1;
               for (int k = 0; k < exponent; k++) begin
                  power = power * 32'd10;
               end
               request.reading = power + 32'($urandom_range(0, 2)) - 32'd1;
            end
         endcase
         if ($urandom_range(0, 1) == 1) begin
            request.reading = -request.reading;
         end
         pending_readings.push_back(request);
      end
      @(negedge reset);
      while (pending_readings.size() != 0 || push) begin
         @(posedge clock);
      end
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/sdf_pkg.sv
rtl/core/sdf_front.sv
rtl/core/sdf_queue.sv
rtl/core/sdf_back.sv
rtl/core/signed_decimal_text_formatter_top.sv
tb/signed_decimal_text_formatter_top_test.sv
